// ===== design/md5_hash_stream_top_defines.svh =====
// ----------------------------------------------------------------------------
// md5 hash stream assertion macros
// shared property forms for the checker of the digest block
// ----------------------------------------------------------------------------
`ifndef MD5_HASH_STREAM_TOP_DEFINES_SVH
`define MD5_HASH_STREAM_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define MD5HS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 hash stream check failed");

// next-cycle implication, masked while reset is high
`define MD5HS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 hash stream check failed");

// next-cycle implication that also holds across reset
`define MD5HS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("md5 hash stream check failed");

`endif

// ===== design/md5hs_pkg.sv =====
// ----------------------------------------------------------------------------
// md5hs_pkg
// constants, round tables and shared types of the md5 digest block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5hs_pkg;

   // initial chaining words
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // padding
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] FILL_END = 6'd63;

   // block store: two block slots of sixteen words
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned RAM_DEPTH = 32;
   localparam int unsigned RAM_AW   = 5;

   localparam logic [5:0] ROUND_LAST = 6'd63;

   // additive round constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amounts, indexed by {phase, round mod 4}
   localparam logic [4:0] ROT_TAB [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic {
      F_DATA,
      F_PAD
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ROUND,
      B_UPDATE,
      B_EMIT
   } back_state_type;

   // one queued block
   typedef struct packed {
      logic last_blk;
   } blk_desc_type;

   // message word taken in a given round
   function automatic logic [3:0] msg_sel(input logic [5:0] rnd);
      logic [3:0] r4;
      logic [3:0] sel;
      r4 = rnd[3:0];
      unique case (rnd[5:4])
         2'd0: sel = r4;
         2'd1: sel = 4'(r4 * 4'd5 + 4'd1);
         2'd2: sel = 4'(r4 * 4'd3 + 4'd5);
         2'd3: sel = 4'(r4 * 4'd7);
      endcase
      return sel;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      return ROT_TAB[{rnd[5:4], rnd[1:0]}];
   endfunction

endpackage

`default_nettype wire

// ===== design/md5hs_ram.sv =====
// ----------------------------------------------------------------------------
// md5hs_ram
// generic simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5hs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/md5hs_queue.sv =====
// ----------------------------------------------------------------------------
// md5hs_queue
// two-entry queue of block descriptors between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5hs_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire md5hs_pkg::blk_desc_type  push_desc,
   input  wire logic                     pop,
   output md5hs_pkg::blk_desc_type       head_desc,
   output logic                          empty
);
   import md5hs_pkg::*;

   blk_desc_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == 2'd0);

endmodule

`default_nettype wire

// ===== design/md5hs_front.sv =====
// ----------------------------------------------------------------------------
// md5hs_front
// takes message bytes, packs words into the block store, appends padding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5hs_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_has_byte,
   input  wire logic                               req_last,
   output logic                                    req_full,
   output logic                                    ram_wr_en,
   output logic [md5hs_pkg::RAM_AW-1:0]            ram_wr_addr,
   output logic [md5hs_pkg::WORD_W-1:0]            ram_wr_data,
   output logic                                    blk_push,
   output md5hs_pkg::blk_desc_type                 blk_desc,
   input  wire logic                               blk_release
);
   import md5hs_pkg::*;

   front_state_type state_ff, state_in;
   logic [5:0]      fill_ff, fill_in;
   logic            slot_ff, slot_in;
   logic [1:0]      used_ff, used_in;
   logic [63:0]     count_ff, count_in;
   logic [23:0]     hold_ff, hold_in;
   logic            mark_done_ff, mark_done_in;
   logic            len_ok_ff, len_ok_in;

   logic            can_wr;
   logic            accept;
   logic            wr_en;
   logic [7:0]      wr_byte;
   logic [7:0]      pad_byte;
   logic [63:0]     bit_len;
   logic            blk_done;
   logic            desc_last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_DATA: begin
            if (accept && req_last) begin
               state_in = F_PAD;
            end
         end
         F_PAD: begin
            if (blk_done && desc_last) begin
               state_in = F_DATA;
            end
         end
      endcase
   end

   // pad byte: mark, zero fill, then the bit length low byte first
   always_comb begin
      bit_len = {count_ff[60:0], 3'b000};
      if (!mark_done_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_ok_ff && (fill_ff >= LEN_POS)) begin
         pad_byte = bit_len[{fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // outputs of the state machine
   always_comb begin
      can_wr    = (used_ff != 2'd2);
      req_full  = (state_ff != F_DATA) || !can_wr;
      accept    = req_push && !req_full;
      wr_en     = 1'b0;
      wr_byte   = req_data_byte;
      desc_last = 1'b0;
      unique case (state_ff)
         F_DATA: begin
            wr_en   = accept && req_has_byte;
            wr_byte = req_data_byte;
         end
         F_PAD: begin
            wr_en     = can_wr;
            wr_byte   = pad_byte;
            desc_last = mark_done_ff && len_ok_ff;
         end
      endcase
      blk_done          = wr_en && (fill_ff == FILL_END);
      blk_push          = blk_done;
      blk_desc.last_blk = desc_last;
      ram_wr_en         = wr_en && (fill_ff[1:0] == 2'd3);
      ram_wr_addr       = {slot_ff, fill_ff[5:2]};
      ram_wr_data       = {wr_byte, hold_ff};
   end

   // byte packing, counters and padding flags
   always_comb begin
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      hold_in      = hold_ff;
      mark_done_in = mark_done_ff;
      len_ok_in    = len_ok_ff;
      if (wr_en) begin
         fill_in = fill_ff + 6'd1;
         unique case (fill_ff[1:0])
            2'd0:    hold_in[7:0]   = wr_byte;
            2'd1:    hold_in[15:8]  = wr_byte;
            2'd2:    hold_in[23:16] = wr_byte;
            default: hold_in        = hold_ff;
         endcase
      end
      if (blk_done) begin
         slot_in = ~slot_ff;
      end
      if (state_ff == F_DATA) begin
         if (accept && req_has_byte) begin
            count_in = count_ff + 64'd1;
         end
         if (accept && req_last) begin
            mark_done_in = 1'b0;
            len_ok_in    = 1'b0;
         end
      end else if (wr_en) begin
         if (!mark_done_ff) begin
            mark_done_in = 1'b1;
            len_ok_in    = (fill_ff < LEN_POS);
         end
         if (blk_done) begin
            len_ok_in = 1'b1;
            if (desc_last) begin
               count_in = 64'd0;
            end
         end
      end
   end

   // slots held by blocks not yet compressed
   always_comb begin
      unique case ({blk_push, blk_release})
         2'b10:   used_in = used_ff + 2'd1;
         2'b01:   used_in = used_ff - 2'd1;
         default: used_in = used_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_DATA;
         fill_ff      <= 6'd0;
         slot_ff      <= 1'b0;
         used_ff      <= 2'd0;
         count_ff     <= 64'd0;
         mark_done_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         mark_done_ff <= mark_done_in;
         len_ok_ff    <= len_ok_in;
      end
   end

   // partial word bytes
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

// ===== design/md5hs_back.sv =====
// ----------------------------------------------------------------------------
// md5hs_back
// round engine: one md5 round per cycle, chaining words and digest register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5hs_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire md5hs_pkg::blk_desc_type      q_head,
   output logic                              q_pop,
   output logic [md5hs_pkg::RAM_AW-1:0]      rd_addr,
   input  wire logic [md5hs_pkg::WORD_W-1:0] rd_data,
   output logic                              blk_release,
   input  wire logic                         rsp_pop,
   output logic                              rsp_empty,
   output logic [31:0]                       rsp_digest_word0,
   output logic [31:0]                       rsp_digest_word1,
   output logic [31:0]                       rsp_digest_word2,
   output logic [31:0]                       rsp_digest_word3
);
   import md5hs_pkg::*;

   back_state_type state_ff, state_in;
   logic [5:0]     round_ff;
   logic           slot_ff;
   logic           last_blk_ff;
   logic           rsp_valid_ff;
   logic [31:0]    chain_a_ff, chain_b_ff, chain_c_ff, chain_d_ff;
   logic [31:0]    a_ff, b_ff, c_ff, d_ff;

   logic           rsp_free;
   logic           load_rsp;
   logic [5:0]     next_round;
   logic [31:0]    mix;
   logic [31:0]    sum;
   logic [63:0]    rot_wide;
   logic [31:0]    b_next;

   assign rsp_free   = !rsp_valid_ff || rsp_pop;
   assign next_round = round_ff + 6'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            state_in = last_blk_ff ? B_EMIT : B_IDLE;
         end
         B_EMIT: begin
            if (rsp_free) begin
               state_in = B_IDLE;
            end
         end
      endcase
   end

   // outputs of the state machine; word for the next round is fetched ahead
   always_comb begin
      q_pop       = (state_ff == B_IDLE) && !q_empty;
      blk_release = (state_ff == B_UPDATE);
      load_rsp    = (state_ff == B_EMIT) && rsp_free;
      if (state_ff == B_IDLE) begin
         rd_addr = {slot_ff, msg_sel(6'd0)};
      end else begin
         rd_addr = {slot_ff, msg_sel(next_round)};
      end
   end

   // one md5 round
   always_comb begin
      unique case (round_ff[5:4])
         2'd0: mix = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: mix = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: mix = b_ff ^ c_ff ^ d_ff;
         2'd3: mix = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum      = mix + a_ff + ROUND_K[round_ff] + rd_data;
      rot_wide = {sum, sum} << rot_amount(round_ff);
      b_next   = b_ff + rot_wide[63:32];
   end

   // control registers and chaining words
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         slot_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_a_ff   <= INIT_A;
         chain_b_ff   <= INIT_B;
         chain_c_ff   <= INIT_C;
         chain_d_ff   <= INIT_D;
      end else begin
         state_ff <= state_in;
         if (blk_release) begin
            slot_ff    <= ~slot_ff;
            chain_a_ff <= chain_a_ff + a_ff;
            chain_b_ff <= chain_b_ff + b_ff;
            chain_c_ff <= chain_c_ff + c_ff;
            chain_d_ff <= chain_d_ff + d_ff;
         end else if (load_rsp) begin
            chain_a_ff <= INIT_A;
            chain_b_ff <= INIT_B;
            chain_c_ff <= INIT_C;
            chain_d_ff <= INIT_D;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working words, round counter and digest register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_ff        <= chain_a_ff;
         b_ff        <= chain_b_ff;
         c_ff        <= chain_c_ff;
         d_ff        <= chain_d_ff;
         round_ff    <= 6'd0;
         last_blk_ff <= q_head.last_blk;
      end else if (state_ff == B_ROUND) begin
         a_ff     <= d_ff;
         d_ff     <= c_ff;
         c_ff     <= b_ff;
         b_ff     <= b_next;
         round_ff <= next_round;
      end
      if (load_rsp) begin
         rsp_digest_word0 <= chain_a_ff;
         rsp_digest_word1 <= chain_b_ff;
         rsp_digest_word2 <= chain_c_ff;
         rsp_digest_word3 <= chain_d_ff;
      end
   end

   assign rsp_empty = !rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/md5_hash_stream_top.sv =====
// ----------------------------------------------------------------------------
// md5_hash_stream_top
// streaming md5 digest: byte front end, block queue, round engine
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  request   req_push/full, data_byte, has_byte,     push && !full
//            last
//  response  rsp_pop/empty, digest_word0..3          pop && !empty
//
//  a byte is taken each cycle while one of the two block slots is free
//  a block passes the round engine in order: start, 64 rounds, chain add
//  a last item holds full high while padding is written, one byte a cycle while
//  a block slot is free, to the end of the final block; the digest follows its compression
//  synchronous reset, no clearing pass; a waiting digest stalls only the
//  round engine, the front end keeps filling its free slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_hash_stream_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_last,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [31:0]      rsp_digest_word0,
   output logic [31:0]      rsp_digest_word1,
   output logic [31:0]      rsp_digest_word2,
   output logic [31:0]      rsp_digest_word3
);
   import md5hs_pkg::*;

   logic                ram_wr_en;
   logic [RAM_AW-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic [RAM_AW-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;
   logic                blk_push;
   blk_desc_type        blk_desc;
   logic                blk_release;
   logic                q_pop;
   logic                q_empty;
   blk_desc_type        q_head;

   // byte intake and padding
   md5hs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .req_full      (req_full),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .blk_push      (blk_push),
      .blk_desc      (blk_desc),
      .blk_release   (blk_release)
   );

   // two block slots of message words
   md5hs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // full blocks waiting for the round engine
   md5hs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (blk_push),
      .push_desc (blk_desc),
      .pop       (q_pop),
      .head_desc (q_head),
      .empty     (q_empty)
   );

   // compression and digest output
   md5hs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rd_addr          (ram_rd_addr),
      .rd_data          (ram_rd_data),
      .blk_release      (blk_release),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_digest_word0 (rsp_digest_word0),
      .rsp_digest_word1 (rsp_digest_word1),
      .rsp_digest_word2 (rsp_digest_word2),
      .rsp_digest_word3 (rsp_digest_word3)
   );

endmodule

`default_nettype wire

// ===== design/md5hs_checker.sv =====
// ----------------------------------------------------------------------------
// md5hs_checker
// port-level checks of the md5 digest block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "md5_hash_stream_top_defines.svh"

module md5hs_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_last,
   input  wire logic        req_full,
   input  wire logic        rsp_pop,
   input  wire logic        rsp_empty,
   input  wire logic [31:0] rsp_digest_word0,
   input  wire logic [31:0] rsp_digest_word1,
   input  wire logic [31:0] rsp_digest_word2,
   input  wire logic [31:0] rsp_digest_word3
);

   logic         last_xfer;
   logic         rsp_held;
   logic [127:0] rsp_digest;

   assign last_xfer  = req_push && !req_full && req_last;
   assign rsp_held   = !rsp_empty && !rsp_pop;
   assign rsp_digest = {rsp_digest_word0, rsp_digest_word1,
                        rsp_digest_word2, rsp_digest_word3};

   // no digest is waiting straight after reset
   `MD5HS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty)

   // a closing transfer starts padding, so the request side stalls
   `MD5HS_ASSERT_NEXT(a_last_stalls, clock, reset, last_xfer, req_full)

   // a waiting digest stays until taken
   `MD5HS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_held, !rsp_empty && $stable(rsp_digest))

   // a digest on show is fully defined
   `MD5HS_ASSERT_IMPL(a_rsp_known, clock, reset, !rsp_empty, !$isunknown(rsp_digest))

endmodule

bind md5_hash_stream_top md5hs_checker u_checker (.*);

`default_nettype wire
